>>> src/tlpt_pkg.sv
// Shared types and constants of the two-level page table block.
// Used by tlpt_ctrl, tlpt_datapath and two_level_page_table; depends on nothing.
package tlpt_pkg;

    // Pool of page-table slots, 1024 entries each
    localparam int unsigned TABLE_SLOTS = 16;
    localparam int unsigned IDX_W       = 10;
    localparam int unsigned ENTRIES     = 1 << IDX_W;
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned OFF_W       = 12;
    localparam int unsigned FLAGS_W     = 12;
    localparam int unsigned SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int unsigned NS_W        = $clog2(TABLE_SLOTS + 1);
    localparam int unsigned DIR_W       = SLOT_W + 1;
    localparam int unsigned TBL_DEPTH   = TABLE_SLOTS * ENTRIES;
    localparam int unsigned TBL_AW      = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(TABLE_SLOTS);

    // Stream payload widths (fields packed from bit 0, padded to bytes)
    localparam int unsigned S_DATA_W = 80;
    localparam int unsigned M_DATA_W = 40;
    localparam int unsigned M_PAD_W  = M_DATA_W - ADDR_W - 2;

    typedef enum logic [1:0] {
        ACT_MAP   = 2'd0,
        ACT_UNMAP = 2'd1,
        ACT_XLATE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_MISS   = 2'd1,
        ST_NOSLOT = 2'd2
    } status_t;

    // Table RAM address source
    typedef enum logic [1:0] {
        TA_LOOKUP, // slot from directory read, index from request
        TA_CLEAR,  // new slot, sweep counter
        TA_NEW     // new slot, index from request
    } tbl_asel_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR,
        S_ALLOC,
        S_ALLOC_END,
        S_TBL,
        S_RESP
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic      load_req;
        logic      dir_we;
        logic      dir_clear;
        logic      tbl_we;
        tbl_asel_t tbl_asel;
        logic      tbl_wmap;
        logic      cnt_clr;
        logic      cnt_inc;
        logic      slot_adv;
        logic      pend_load;
        status_t   pend_status;
        logic      pend_xlate;
        logic      out_load;
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        action_t action;
        logic    dir_hit;
        logic    pool_full;
        logic    present;
        logic    cnt_last;
        logic    out_free;
    } ctrl_stat_t;

endpackage

>>> src/tlpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlpt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/tlpt_ctrl.sv
// Controller FSM of the page table: reset clearing pass, directory lookup,
// slot allocation sweep, table read and result hand-off. Depends on tlpt_pkg.
module tlpt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  tlpt_pkg::ctrl_stat_t stat,
    output tlpt_pkg::ctrl_cmd_t  cmd
);
    import tlpt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next       = state_reg;
        s_tready         = 1'b0;
        cmd              = '0;
        cmd.tbl_asel     = TA_LOOKUP;
        cmd.pend_status  = ST_DONE;

        unique case (state_reg)
            // Sweep the directory to all-absent after reset
            S_CLEAR: begin
                cmd.dir_we    = 1'b1;
                cmd.dir_clear = 1'b1;
                cmd.cnt_inc   = 1'b1;
                if (stat.cnt_last) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DIR;
                end
            end

            // Directory entry is on the read port
            S_DIR: begin
                state_next     = S_RESP;
                cmd.pend_load  = 1'b1;
                case (stat.action)
                    ACT_MAP: begin
                        if (stat.dir_hit) begin
                            cmd.tbl_we   = 1'b1;
                            cmd.tbl_wmap = 1'b1;
                        end else if (stat.pool_full) begin
                            cmd.pend_status = ST_NOSLOT;
                        end else begin
                            cmd.pend_load = 1'b0;
                            state_next    = S_ALLOC;
                        end
                    end
                    ACT_UNMAP: begin
                        if (stat.dir_hit) begin
                            cmd.tbl_we = 1'b1;
                        end else begin
                            cmd.pend_status = ST_MISS;
                        end
                    end
                    ACT_XLATE: begin
                        if (stat.dir_hit) begin
                            cmd.pend_load = 1'b0;
                            state_next    = S_TBL;
                        end else begin
                            cmd.pend_status = ST_MISS;
                        end
                    end
                    default: begin
                        cmd.pend_status = ST_DONE;
                    end
                endcase
            end

            // Zero the newly allocated slot, one entry per cycle
            S_ALLOC: begin
                cmd.tbl_we   = 1'b1;
                cmd.tbl_asel = TA_CLEAR;
                cmd.cnt_inc  = 1'b1;
                if (stat.cnt_last) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_ALLOC_END;
                end
            end

            // Bind the directory entry and write the page entry
            S_ALLOC_END: begin
                cmd.dir_we    = 1'b1;
                cmd.tbl_we    = 1'b1;
                cmd.tbl_asel  = TA_NEW;
                cmd.tbl_wmap  = 1'b1;
                cmd.slot_adv  = 1'b1;
                cmd.pend_load = 1'b1;
                state_next    = S_RESP;
            end

            // Page entry is on the read port
            S_TBL: begin
                cmd.pend_load = 1'b1;
                if (stat.present) begin
                    cmd.pend_xlate = 1'b1;
                end else begin
                    cmd.pend_status = ST_MISS;
                end
                state_next = S_RESP;
            end

            // Hand result to the output register; overlap the next request
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    s_tready     = 1'b1;
                    if (s_tvalid) begin
                        cmd.load_req = 1'b1;
                        state_next   = S_DIR;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
        endcase
    end

endmodule

>>> src/tlpt_datapath.sv
// Datapath of the page table: request registers, directory and table RAMs,
// slot allocator, sweep counter and result registers. Depends on tlpt_pkg, tlpt_ram.
module tlpt_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [tlpt_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [tlpt_pkg::M_DATA_W-1:0]   m_tdata,
    input  tlpt_pkg::ctrl_cmd_t             cmd,
    output tlpt_pkg::ctrl_stat_t            stat
);
    import tlpt_pkg::*;

    // Unpacked request fields
    logic [1:0]         in_action;
    logic [ADDR_W-1:0]  in_va;
    logic [ADDR_W-1:0]  in_pa;
    logic [FLAGS_W-1:0] in_flags;

    assign in_action = s_tdata[1:0];
    assign in_va     = s_tdata[33:2];
    assign in_pa     = s_tdata[65:34];
    assign in_flags  = s_tdata[77:66];

    // Request registers (payload, no reset)
    action_t            act_reg;
    logic [ADDR_W-1:0]  va_reg;
    logic [ADDR_W-1:0]  pa_reg;
    logic [FLAGS_W-1:0] flags_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            act_reg   <= action_t'(in_action);
            va_reg    <= in_va;
            pa_reg    <= in_pa;
            flags_reg <= in_flags;
        end
    end

    logic [IDX_W-1:0] dir_idx, tbl_idx;
    assign dir_idx = va_reg[31:22];
    assign tbl_idx = va_reg[21:12];

    // Allocation pointer and sweep counter
    logic [NS_W-1:0]  next_slot_reg, next_slot_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        next_slot_next = next_slot_reg;
        if (cmd.slot_adv) begin
            next_slot_next = next_slot_reg + NS_W'(1);
        end
        cnt_next = cnt_reg;
        if (cmd.cnt_clr) begin
            cnt_next = '0;
        end else if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_slot_reg <= '0;
            cnt_reg       <= '0;
        end else begin
            next_slot_reg <= next_slot_next;
            cnt_reg       <= cnt_next;
        end
    end

    logic [SLOT_W-1:0] new_slot;
    assign new_slot = SLOT_W'(next_slot_reg);

    // Directory RAM: {present, slot}
    logic [IDX_W-1:0] dir_raddr, dir_waddr;
    logic [DIR_W-1:0] dir_wdata, dir_rdata;
    logic [SLOT_W-1:0] rd_slot;

    assign dir_raddr = cmd.load_req ? in_va[31:22] : dir_idx;
    assign dir_waddr = cmd.dir_clear ? cnt_reg : dir_idx;
    assign dir_wdata = cmd.dir_clear ? '0 : {1'b1, new_slot};
    assign rd_slot   = dir_rdata[SLOT_W-1:0];

    tlpt_ram #(
        .WIDTH (DIR_W),
        .DEPTH (ENTRIES)
    ) u_dir_ram (
        .aclk  (aclk),
        .we    (cmd.dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .raddr (dir_raddr),
        .rdata (dir_rdata)
    );

    // Table RAM: page entries of all slots
    logic [TBL_AW-1:0] lookup_addr, tbl_waddr;
    logic [ADDR_W-1:0] tbl_wdata, tbl_rdata;

    assign lookup_addr = TBL_AW'({rd_slot, tbl_idx});
    assign tbl_wdata   = cmd.tbl_wmap
                       ? {pa_reg[31:12], flags_reg[FLAGS_W-1:1], 1'b1}
                       : '0;

    always_comb begin
        unique case (cmd.tbl_asel)
            TA_LOOKUP: tbl_waddr = lookup_addr;
            TA_CLEAR:  tbl_waddr = TBL_AW'({new_slot, cnt_reg});
            TA_NEW:    tbl_waddr = TBL_AW'({new_slot, tbl_idx});
            default:   tbl_waddr = lookup_addr;
        endcase
    end

    tlpt_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .aclk  (aclk),
        .we    (cmd.tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (lookup_addr),
        .rdata (tbl_rdata)
    );

    // Pending result, then output register
    logic [ADDR_W-1:0] pend_addr_reg, out_addr_reg;
    status_t           pend_status_reg, out_status_reg;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (cmd.pend_load) begin
            pend_addr_reg   <= cmd.pend_xlate ? {tbl_rdata[31:12], va_reg[OFF_W-1:0]} : '0;
            pend_status_reg <= cmd.pend_status;
        end
        if (cmd.out_load) begin
            out_addr_reg   <= pend_addr_reg;
            out_status_reg <= pend_status_reg;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_status_reg, out_addr_reg};

    // Status to the controller
    assign stat.action    = act_reg;
    assign stat.dir_hit   = dir_rdata[DIR_W-1] && ({1'b0, rd_slot} < SLOT_LIMIT);
    assign stat.pool_full = (next_slot_reg == NS_W'(TABLE_SLOTS));
    assign stat.present   = tbl_rdata[0];
    assign stat.cnt_last  = &cnt_reg;
    assign stat.out_free  = !out_valid_reg || m_tready;

endmodule

>>> src/two_level_page_table.sv
// Top level of the two-level page table.
// Depends on tlpt_pkg, tlpt_ctrl, tlpt_datapath (and tlpt_ram below it).
//
// Usage:
//   s_ channel: one request per handshake: map, unmap or translate (any other action code is answered with done).
//   m_ channel: exactly one result per request, in request order:
//     the translated address (zero unless a translate hits) and a status
//     (done, not mapped, no table slot left).
//   Path from accept to m_tvalid: directory RAM read, for translates then a
//   table RAM read (each registered), then the pending and output registers.
//   A map that needs a new table slot first zeroes the slot one entry per
//   cycle through the single table RAM write port.
//   The next request is taken in the cycle its predecessor's result moves
//   to the output register.
//   After reset the directory RAM is swept to all-absent with s_tready low.
//   Slots are never freed.
//   A stalled receiver holds the result in the output register; one further
//   result waits in a pending register, after which s_tready stays low.
module two_level_page_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] action, [33:2] vaddr, [65:34] paddr, [77:66] flags
    input  logic [tlpt_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] result_addr, [33:32] status
    output logic [tlpt_pkg::M_DATA_W-1:0] m_tdata
);
    import tlpt_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    tlpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tlpt_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

>>> verif/testbench.sv
// Self-checking bench for two_level_page_table: directed table, random requests, then slot pool exhaustion.
// Holds its own page-walk predictor; depends only on tlpt_pkg and the DUT.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tlpt_pkg::*;

    // action code the block answers but does not act on
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int unsigned S_PAD_W   = S_DATA_W - 78;
    localparam int unsigned RAND_REQS = 1000;
    localparam int unsigned DRAIN_AT  = 700;
    localparam int unsigned HOLD_AT   = 350;
    localparam int unsigned HOLD_LEN  = 400;

    // request fields, action in the low bits as on s_tdata
    typedef struct packed {
        logic [FLAGS_W-1:0] flags;
        logic [ADDR_W-1:0]  paddr;
        logic [ADDR_W-1:0]  vaddr;
        logic [1:0]         action;
    } pt_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        status_t           status;
    } pt_result_t;

    // one directed request; typed rows carry their own answer
    typedef struct packed {
        logic [1:0]         action;
        logic [ADDR_W-1:0]  vaddr;
        logic [ADDR_W-1:0]  paddr;
        logic [FLAGS_W-1:0] flags;
        logic               typed;
        logic [ADDR_W-1:0]  exp_addr;
        status_t            exp_status;
    } dir_row_t;

    localparam dir_row_t DIRECTED [16] = '{
        // nothing mapped after reset
        '{ACT_XLATE, 32'h0000_0000, 32'h0000_0000, 12'h000, 1'b1, 32'h0, ST_MISS},
        '{ACT_UNMAP, 32'hFFFF_FFFF, 32'h0000_0000, 12'h000, 1'b1, 32'h0, ST_MISS},
        // unused action code, all ones everywhere
        '{ACT_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 1'b1, 32'h0, ST_DONE},
        // first and last directory / table entries, extreme frames and flags
        '{ACT_MAP,   32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF, 1'b1, 32'h0, ST_DONE},
        '{ACT_XLATE, 32'h0000_0FFF, 32'h0000_0000, 12'h000, 1'b1, 32'hFFFF_FFFF, ST_DONE},
        '{ACT_MAP,   32'hFFFF_F000, 32'h0000_0000, 12'h000, 1'b1, 32'h0, ST_DONE},
        // present bit forced even with flags zero
        '{ACT_XLATE, 32'hFFFF_FABC, 32'hFFFF_FFFF, 12'hFFF, 1'b1, 32'h0000_0ABC, ST_DONE},
        // map into an existing table, then remap over it
        '{ACT_MAP,   32'h0000_1000, 32'h1234_5678, 12'h0A6, 1'b0, 32'h0, ST_DONE},
        '{ACT_XLATE, 32'h0000_1234, 32'h0000_0000, 12'h000, 1'b0, 32'h0, ST_DONE},
        '{ACT_MAP,   32'h0000_1000, 32'hABCD_E000, 12'h001, 1'b0, 32'h0, ST_DONE},
        '{ACT_XLATE, 32'h0000_1FFF, 32'h0000_0000, 12'h000, 1'b0, 32'h0, ST_DONE},
        // unmap of a present entry, then a miss on it
        '{ACT_UNMAP, 32'h0000_1000, 32'h0000_0000, 12'h000, 1'b1, 32'h0, ST_DONE},
        '{ACT_XLATE, 32'h0000_1000, 32'h0000_0000, 12'h000, 1'b1, 32'h0, ST_MISS},
        // directory present, page entry never set
        '{ACT_UNMAP, 32'h0000_2000, 32'h0000_0000, 12'h000, 1'b1, 32'h0, ST_DONE},
        '{ACT_XLATE, 32'h0000_2000, 32'h0000_0000, 12'h000, 1'b1, 32'h0, ST_MISS},
        // directory entry absent
        '{ACT_XLATE, 32'h0040_0000, 32'h0000_0000, 12'h000, 1'b1, 32'h0, ST_MISS}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;

    // page-table mirror
    bit          dir_present [ENTRIES];
    int unsigned dir_slot_of [ENTRIES];
    int unsigned slots_used;
    bit [31:0]   pte_mirror [int];
    logic [9:0]  live_dirs [$];

    pt_result_t  predicted_results [$];
    int unsigned mismatch_count;
    int unsigned results_seen;

    two_level_page_table uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Walk the mirror for one request and apply its side effects
    function automatic pt_result_t page_walk(input pt_req_t r);
        logic [9:0] di;
        logic [9:0] ti;
        bit         hit;
        int         key;
        int         j;
        pt_result_t res;
        di         = r.vaddr[31:22];
        ti         = r.vaddr[21:12];
        res.addr   = '0;
        res.status = ST_DONE;
        hit        = dir_present[di] && (dir_slot_of[di] < TABLE_SLOTS);
        key        = dir_slot_of[di] * ENTRIES + ti;
        case (r.action)
            ACT_MAP: begin
                if (!hit) begin
                    if (slots_used >= TABLE_SLOTS) begin
                        res.status = ST_NOSLOT;
                    end else begin
                        // fresh slot starts cleared
                        for (j = 0; j < ENTRIES; j++) begin
                            if (pte_mirror.exists(slots_used * ENTRIES + j))
                                pte_mirror.delete(slots_used * ENTRIES + j);
                        end
                        dir_present[di] = 1'b1;
                        dir_slot_of[di] = slots_used;
                        key             = slots_used * ENTRIES + ti;
                        slots_used++;
                        live_dirs.push_back(di);
                    end
                end
                if (res.status == ST_DONE)
                    pte_mirror[key] = {r.paddr[31:12], 12'h000} | r.flags | 32'h1;
            end
            ACT_UNMAP: begin
                if (hit)
                    pte_mirror[key] = '0;
                else
                    res.status = ST_MISS;
            end
            ACT_XLATE: begin
                if (hit && pte_mirror.exists(key) && pte_mirror[key][0])
                    res.addr = {pte_mirror[key][31:12], r.vaddr[11:0]};
                else
                    res.status = ST_MISS;
            end
            default: ;
        endcase
        return res;
    endfunction

    // Mostly known directories and a few table indexes, so walks hit
    function automatic pt_req_t random_request();
        pt_req_t     r;
        int unsigned pick;
        logic [9:0]  di;
        logic [9:0]  ti;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            r.action = ACT_MAP;
        else if (pick < 50)
            r.action = ACT_UNMAP;
        else if (pick < 95)
            r.action = ACT_XLATE;
        else
            r.action = ACT_SPARE;
        pick = $urandom_range(0, 99);
        if (pick < 80 && live_dirs.size() != 0)
            di = live_dirs[$urandom_range(0, live_dirs.size() - 1)];
        else
            di = 10'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70)
            ti = 10'($urandom_range(0, 7));
        else if (pick < 80)
            ti = 10'(1023 - $urandom_range(0, 3));
        else
            ti = 10'($urandom);
        r.vaddr = {di, ti, 12'($urandom)};
        r.paddr = $urandom;
        r.flags = 12'($urandom);
        return r;
    endfunction

    // Present one request until accepted; record what it should return
    task automatic offer(input pt_req_t r, input bit typed, input pt_result_t typed_res);
        pt_result_t walked;
        s_tdata  <= {{S_PAD_W{1'b0}}, r};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        walked = page_walk(r);
        predicted_results.push_back(typed ? typed_res : walked);
        @(negedge aclk);
    endtask

    task automatic idle(input int unsigned cycles);
        if (cycles != 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(negedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (predicted_results.size() != 0) @(negedge aclk);
    endtask

    // Request source
    initial begin : stimulus
        pt_req_t     r;
        pt_result_t  typed_res;
        int unsigned sent;
        int unsigned burst;
        logic [9:0]  di;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (DIRECTED[i]) begin
            r.action         = DIRECTED[i].action;
            r.vaddr          = DIRECTED[i].vaddr;
            r.paddr          = DIRECTED[i].paddr;
            r.flags          = DIRECTED[i].flags;
            typed_res.addr   = DIRECTED[i].exp_addr;
            typed_res.status = DIRECTED[i].exp_status;
            offer(r, DIRECTED[i].typed, typed_res);
            idle($urandom_range(0, 2));
        end

        // random bursts with random gaps
        sent = 0;
        while (sent < RAND_REQS) begin
            burst = $urandom_range(1, 24);
            while (burst != 0 && sent < RAND_REQS) begin
                offer(random_request(), 1'b0, '0);
                sent++;
                burst--;
                if (sent == DRAIN_AT)
                    drain_results();
            end
            if ($urandom_range(0, 3) != 0)
                idle($urandom_range(1, 8));
        end

        // use up the slot pool, then one map too many
        while (slots_used <= TABLE_SLOTS) begin
            do di = 10'($urandom); while (dir_present[di]);
            r.action = ACT_MAP;
            r.vaddr  = {di, 22'($urandom)};
            r.paddr  = $urandom;
            r.flags  = 12'($urandom);
            offer(r, 1'b0, '0);
            if (slots_used == TABLE_SLOTS && !dir_present[di]) begin
                // no slot left: this directory stays absent
                r.action = ACT_XLATE;
                offer(r, 1'b0, '0);
                r.action = ACT_UNMAP;
                offer(r, 1'b0, '0);
                break;
            end
        end

        drain_results();
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result sink: changing stall modes plus one long hold-off
    initial begin : result_sink
        int unsigned tick;
        int unsigned hold_left;
        bit          hold_done;
        m_tready  = 1'b0;
        tick      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            tick++;
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case ((tick / 80) % 3)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 2) != 0);
                    default: m_tready <= (tick % 5 == 0);
                endcase
            end
        end
    end

    // Compare each result request against the oldest prediction
    always @(posedge aclk) begin : result_check
        pt_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (predicted_results.size() == 0) begin
                $display("%0t: unexpected result addr=%h status=%0d", $time,
                         m_tdata[ADDR_W-1:0], m_tdata[ADDR_W+1:ADDR_W]);
                mismatch_count++;
            end else begin
                want = predicted_results.pop_front();
                if (m_tdata[ADDR_W-1:0] !== want.addr) begin
                    $display("%0t: result_addr expected %h actual %h", $time,
                             want.addr, m_tdata[ADDR_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[ADDR_W+1:ADDR_W] !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, m_tdata[ADDR_W+1:ADDR_W]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
src/tlpt_pkg.sv
src/tlpt_ram.sv
src/tlpt_ctrl.sv
src/tlpt_datapath.sv
src/two_level_page_table.sv
verif/testbench.sv
